>>> design/dvrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the distance-vector route table unit.
package dvrt_pkg;

   localparam int FUNC_W     = 2;
   localparam int NODE_W     = 4;
   localparam int DIST_W     = 8;
   localparam int NEXT_W     = 5;
   localparam int OUT_DIST_W = 9;
   localparam int CNT_W      = 5;

   localparam logic [DIST_W-1:0] DIST_UNKNOWN = 8'hFF;
   localparam logic [DIST_W-1:0] DIST_MAX     = 8'hFE;
   localparam logic [DIST_W-1:0] DIST_SELF    = 8'h00;
   localparam logic [DIST_W-1:0] DIST_LINK    = 8'h01;
   localparam logic [CNT_W-1:0]  COUNT_RESET  = 5'd16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LINK  = 2'd1,
      FUNC_EXCH  = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_LOAD    = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_LINK_AB = 3'd3,
      OP_LINK_BA = 3'd4,
      OP_XSRC    = 3'd5,
      OP_XDST    = 3'd6,
      OP_READ    = 3'd7
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     reject;
      logic     clr_last;
      logic     exch_last;
      logic     rsp_free;
   } dp_stat_type;

   typedef struct packed {
      logic [DIST_W-1:0] hop_dist;
      logic [NEXT_W-1:0] nhop;
   } entry_type;

endpackage

>>> design/dvrt_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer for the route table unit.
module dvrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  dvrt_pkg::dp_stat_type stat,
   output dvrt_pkg::ctl_cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_CLEAR    = 9'b000000100,
      S_LINK_AB  = 9'b000001000,
      S_LINK_BA  = 9'b000010000,
      S_XSRC     = 9'b000100000,
      S_XDST     = 9'b001000000,
      S_READ     = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.op       = dvrt_pkg::OP_NOP;
      cmd.rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = dvrt_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.reject) begin
               state_in = S_DONE;
            end else begin
               unique case (stat.func)
                  dvrt_pkg::FUNC_CLEAR: state_in = S_CLEAR;
                  dvrt_pkg::FUNC_LINK:  state_in = S_LINK_AB;
                  dvrt_pkg::FUNC_EXCH:  state_in = S_XSRC;
                  dvrt_pkg::FUNC_READ:  state_in = S_READ;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.op = dvrt_pkg::OP_CLEAR;
            if (stat.clr_last) state_in = S_DONE;
         end
         S_LINK_AB: begin
            cmd.op   = dvrt_pkg::OP_LINK_AB;
            state_in = S_LINK_BA;
         end
         S_LINK_BA: begin
            cmd.op   = dvrt_pkg::OP_LINK_BA;
            state_in = S_DONE;
         end
         S_XSRC: begin
            cmd.op   = dvrt_pkg::OP_XSRC;
            state_in = S_XDST;
         end
         S_XDST: begin
            cmd.op   = dvrt_pkg::OP_XDST;
            state_in = stat.exch_last ? S_DONE : S_XSRC;
         end
         S_READ: begin
            cmd.op   = dvrt_pkg::OP_READ;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // an exchange keeps alternating source and destination reads until the last one
   a_exch_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_XDST && !stat.exch_last) |=> (state_ff == S_XSRC))
      else $error("exchange walk left early");
`endif

endmodule

>>> design/dvrt_datapath.sv
`timescale 1ns / 1ps
// Table memory, item registers, counters and result register of the route table unit.
module dvrt_datapath #(
   parameter int MAX_NODES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dvrt_pkg::ctl_cmd_type               cmd,
   output dvrt_pkg::dp_stat_type               stat,
   input  logic [dvrt_pkg::FUNC_W-1:0]         req_func,
   input  logic [dvrt_pkg::NODE_W-1:0]         req_node_a,
   input  logic [dvrt_pkg::NODE_W-1:0]         req_node_b,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dvrt_pkg::CNT_W-1:0]          csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_status,
   output logic [dvrt_pkg::OUT_DIST_W-1:0]     rsp_distance,
   output logic [dvrt_pkg::NEXT_W-1:0]         rsp_next_hop
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = ($clog2(MAX_NODES + 1) > dvrt_pkg::CNT_W) ?
                          $clog2(MAX_NODES + 1) : dvrt_pkg::CNT_W;
   localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

   function automatic logic [AW-1:0] addr_of(logic [AW-1:0] owner, logic [AW-1:0] dest);
      return owner * AW'(MAX_NODES) + dest;
   endfunction

   // configuration
   logic [dvrt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]              eff_count;

   // item registers and walk counters
   dvrt_pkg::func_type          func_ff, func_in;
   logic [dvrt_pkg::NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic                        reject_ff, reject_in;
   logic [NW-1:0]               o_ff, o_in, d_ff, d_in;

   // exchange commit
   logic                        pend_ff, pend_in;
   logic [dvrt_pkg::DIST_W-1:0] src_dist_ff, src_dist_in;
   logic [AW-1:0]               waddr_ff, waddr_in;
   logic [dvrt_pkg::DIST_W-1:0] new_dist;

   // table memory
   dvrt_pkg::entry_type mem [DEPTH];
   dvrt_pkg::entry_type rdata_ff;
   dvrt_pkg::entry_type wr_data;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic [dvrt_pkg::OUT_DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [dvrt_pkg::NEXT_W-1:0]     rsp_next_ff, rsp_next_in;

   assign eff_count = (CW'(count_ff) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_ff);
   assign csr_ready = 1'b1;
   assign count_in  = csr_valid ? csr_wdata : count_ff;

   assign stat.func      = func_ff;
   assign stat.reject    = reject_ff;
   assign stat.clr_last  = (o_ff == LAST_NODE) && (d_ff == LAST_NODE);
   assign stat.exch_last = (CW'(d_ff) + CW'(1)) == eff_count;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign new_dist = (src_dist_ff >= dvrt_pkg::DIST_MAX) ? dvrt_pkg::DIST_MAX :
                     src_dist_ff + dvrt_pkg::DIST_W'(1);

   always_comb begin
      func_in     = func_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      reject_in   = reject_ff;
      o_in        = o_ff;
      d_in        = d_ff;
      src_dist_in = src_dist_ff;
      waddr_in    = waddr_ff;
      pend_in     = (cmd.op == dvrt_pkg::OP_XDST);
      unique case (cmd.op)
         dvrt_pkg::OP_LOAD: begin
            func_in   = dvrt_pkg::func_type'(req_func);
            a_in      = req_node_a;
            b_in      = req_node_b;
            reject_in = (dvrt_pkg::func_type'(req_func) != dvrt_pkg::FUNC_CLEAR) &&
                        ((CW'(req_node_a) >= eff_count) || (CW'(req_node_b) >= eff_count));
            o_in      = '0;
            d_in      = '0;
         end
         dvrt_pkg::OP_CLEAR: begin
            if (d_ff == LAST_NODE) begin
               d_in = '0;
               o_in = o_ff + NW'(1);
            end else begin
               d_in = d_ff + NW'(1);
            end
         end
         dvrt_pkg::OP_XDST: begin
            d_in        = d_ff + NW'(1);
            src_dist_in = rdata_ff.hop_dist;
            waddr_in    = addr_of(AW'(b_ff), AW'(d_ff));
         end
         default: ;
      endcase
   end

   // memory port selection; a commit lands in the cycle after each destination read
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = waddr_ff;
      wr_data = '{hop_dist: new_dist, nhop: dvrt_pkg::NEXT_W'(a_ff)};
      rd_en   = 1'b0;
      rd_addr = addr_of(AW'(a_ff), AW'(b_ff));
      if (pend_ff && rdata_ff.hop_dist == dvrt_pkg::DIST_UNKNOWN &&
          src_dist_ff != dvrt_pkg::DIST_UNKNOWN) begin
         wr_en = 1'b1;
      end
      unique case (cmd.op)
         dvrt_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(AW'(o_ff), AW'(d_ff));
            if (o_ff == d_ff) begin
               wr_data = '{hop_dist: dvrt_pkg::DIST_SELF, nhop: dvrt_pkg::NEXT_W'(o_ff)};
            end else begin
               wr_data = '{hop_dist: dvrt_pkg::DIST_UNKNOWN, nhop: '0};
            end
         end
         dvrt_pkg::OP_LINK_AB: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(AW'(a_ff), AW'(b_ff));
            wr_data = '{hop_dist: dvrt_pkg::DIST_LINK, nhop: dvrt_pkg::NEXT_W'(b_ff)};
         end
         dvrt_pkg::OP_LINK_BA: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(AW'(b_ff), AW'(a_ff));
            wr_data = '{hop_dist: dvrt_pkg::DIST_LINK, nhop: dvrt_pkg::NEXT_W'(a_ff)};
         end
         dvrt_pkg::OP_XSRC: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(AW'(a_ff), AW'(d_ff));
         end
         dvrt_pkg::OP_XDST: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(AW'(b_ff), AW'(d_ff));
         end
         dvrt_pkg::OP_READ: begin
            rd_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // read data stays put until the next read, so DONE can still see it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_next_in   = rsp_next_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = reject_ff;
         if (func_ff == dvrt_pkg::FUNC_READ && !reject_ff &&
             rdata_ff.hop_dist != dvrt_pkg::DIST_UNKNOWN) begin
            rsp_dist_in = {1'b0, rdata_ff.hop_dist};
            rsp_next_in = rdata_ff.nhop;
         end else begin
            rsp_dist_in = '1;
            rsp_next_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= dvrt_pkg::COUNT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      reject_ff     <= reject_in;
      o_ff          <= o_in;
      d_ff          <= d_in;
      src_dist_ff   <= src_dist_in;
      waddr_ff      <= waddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_next_ff   <= rsp_next_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_next_hop = rsp_next_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an item not yet taken");
   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_dist_ff == '1 && rsp_next_ff == '1))
      else $error("rejected item carries table data");
   a_commit_alone: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cmd.op != dvrt_pkg::OP_CLEAR && cmd.op != dvrt_pkg::OP_LINK_AB &&
                   cmd.op != dvrt_pkg::OP_LINK_BA))
      else $error("exchange commit collides with another write");
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en || rd_en) |-> (int'(wr_addr) < DEPTH && int'(rd_addr) < DEPTH))
      else $error("table address out of range");
`endif

endmodule

>>> design/distance_vector_route_table_unit.sv
`timescale 1ns / 1ps
// Top level of the distance-vector route table unit.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tuser: func; tdata: node_a, node_b
//   rsp      out        rsp_tvalid/rsp_tready   tuser: status; tdata: distance, next_hop
//   csr      in         csr_valid/csr_ready     node_count
//
// An item runs dispatch, its function's steps, then done (a reject skips steps):
// read does one table read, add link two writes, clear all MAX_NODES^2 entries,
// exchange a source and a destination read per node, writing back the next cycle.
// Reset clears the sequencer, node_count (to 16) and the output stage; the tables
// hold nothing useful until the first clear.
// A finished result waits in the output register while the next item is accepted;
// the result after it is held until that one is taken.
module distance_vector_route_table_unit #(
   parameter int MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [7:0]  req_tdata,   // [3:0] node_a, [7:4] node_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] status
   output logic [15:0] rsp_tdata,   // [8:0] distance, [13:9] next_hop, [15:14] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata    // [4:0] node_count
);

   dvrt_pkg::ctl_cmd_type           cmd;
   dvrt_pkg::dp_stat_type           stat;
   logic                            rsp_status;
   logic [dvrt_pkg::OUT_DIST_W-1:0] rsp_distance;
   logic [dvrt_pkg::NEXT_W-1:0]     rsp_next_hop;

   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dvrt_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_tuser),
      .req_node_a   (req_tdata[3:0]),
      .req_node_b   (req_tdata[7:4]),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_distance (rsp_distance),
      .rsp_next_hop (rsp_next_hop)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {2'b00, rsp_next_hop, rsp_distance};

endmodule
